// ===== rtl/core/psn_pkg.sv =====
// Shared types and constants for the five-point Poisson stencil block.
// No dependencies; every other file in rtl/core imports this package.
package psn_pkg;

	// Sizing
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int GRID_SIZE   = 4096;

	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Field widths
	localparam int POS_W       = 12;
	localparam int SIZE_W      = 11;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 12;
	localparam int VAL_W       = 32;
	localparam int COEF_W      = 16;

	// Width that holds a clamped size and a counter plus one
	localparam int DIM_A       = (SIZE_W > COL_W + 1) ? SIZE_W : COL_W + 1;
	localparam int DIM_W       = (DIM_A > ROW_W + 1) ? DIM_A : ROW_W + 1;
	// Coordinate sum before the grid wrap
	localparam int CSUM_W      = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;

	// Arithmetic
	localparam int SUMXY_W     = COEF_W + 1;
	localparam int SUM_W       = VAL_W + 1;
	localparam int PROD_W      = VAL_W + COEF_W + 1;
	localparam int ACC_W       = PROD_W + 3;
	localparam int FRAC_SHIFT  = 12;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX    =
		(ACC_W'(1) <<< (VAL_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_MIN    = -(ACC_W'(1) <<< (VAL_W - 1));

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X    = CFG_IDX_W'(0),
		REG_START_Y    = CFG_IDX_W'(1),
		REG_SUB_WIDTH  = CFG_IDX_W'(2),
		REG_SUB_HEIGHT = CFG_IDX_W'(3)
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  value;
		logic signed [COEF_W-1:0] coef_x;
		logic signed [COEF_W-1:0] coef_y;
	} item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result;
		logic [POS_W-1:0]        col;
		logic [POS_W-1:0]        row;
		logic                    last_of_run;
		logic                    block_done;
	} res_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last_of_run;
		logic             block_done;
	} tag_t;

	// One stencil evaluation, operands already paired up
	typedef struct packed {
		logic signed [VAL_W-1:0]   center;
		logic signed [SUMXY_W-1:0] sum_xy;
		logic signed [COEF_W-1:0]  coef_x;
		logic signed [COEF_W-1:0]  coef_y;
		logic signed [SUM_W-1:0]   sum_ud;
		logic signed [SUM_W-1:0]   sum_lr;
		tag_t                      tag;
	} job_t;

endpackage

// ===== rtl/core/psn_front.sv =====
// Front end: config registers, raster counters, row buffers and job issue.
// Depends on psn_pkg; feeds psn_fifo.
module psn_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [psn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psn_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  psn_pkg::item_t                item,
	output logic                          job_valid,
	input  logic                          job_ready,
	output psn_pkg::job_t                 job
);
	import psn_pkg::*;

	// pending-job bits, issued lowest first
	localparam logic [2:0] PEND_ABOVE = 3'b001;	// point one row up
	localparam logic [2:0] PEND_LEFT  = 3'b010;	// last row, point to the left
	localparam logic [2:0] PEND_SELF  = 3'b100;	// last row, last column

	logic [POS_W-1:0]  start_x_q, start_y_q;
	logic [SIZE_W-1:0] sub_width_q, sub_height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic             last_col, last_row, acc, cfg_hit, cur;
	logic [COL_W-1:0] addr_c, addr_n;

	// row buffers, bank chosen by row parity
	logic signed [VAL_W-1:0]  vbank0_q [MAX_WIDTH];
	logic signed [VAL_W-1:0]  vbank1_q [MAX_WIDTH];
	logic [2*COEF_W-1:0]      cmem_q   [MAX_WIDTH];

	// stage 1
	logic                     valid_s1;
	logic [2:0]               pend_s1;
	logic signed [VAL_W-1:0]  rd0_c_s1, rd0_n_s1, rd1_c_s1, rd1_n_s1;
	logic [2*COEF_W-1:0]      coef_s1;
	logic signed [VAL_W-1:0]  val_s1;
	logic signed [COEF_W-1:0] ax_s1, ay_s1;
	logic [COL_W-1:0]         col_s1;
	logic [ROW_W-1:0]         row_s1;
	logic                     cur_s1, c_gt0_s1, c_gt1_s1, r_gt0_s1, r_gt1_s1, right_s1;

	// history along the current row
	logic signed [VAL_W-1:0]  v1_q, v2_q, pl_q;
	logic signed [COEF_W-1:0] ax1_q, ay1_q;

	logic [2:0]               pick;
	logic                     push, s1_done;
	logic signed [VAL_W-1:0]  prev_c, prev_n, prev2_c;

	always_comb begin
		if (sub_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (DIM_W'(sub_width_q) > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(sub_width_q);
		end
		if (sub_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (DIM_W'(sub_height_q) > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = DIM_W'(sub_height_q);
		end
	end

	assign last_col = (DIM_W'(col_q) + DIM_W'(1)) == w_eff;
	assign last_row = (DIM_W'(row_q) + DIM_W'(1)) == h_eff;
	assign acc      = item_valid && item_ready;
	assign cfg_hit  = cfg_valid && (cfg_index inside {REG_START_X, REG_START_Y,
		REG_SUB_WIDTH, REG_SUB_HEIGHT});
	assign cur      = row_q[0];
	assign addr_c   = col_q;
	assign addr_n   = col_q + COL_W'(1);

	// config registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q    <= '0;
			start_y_q    <= '0;
			sub_width_q  <= SIZE_W'(1);
			sub_height_q <= SIZE_W'(1);
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_START_X:    start_x_q    <= cfg_data[POS_W-1:0];
					REG_START_Y:    start_y_q    <= cfg_data[POS_W-1:0];
					REG_SUB_WIDTH:  sub_width_q  <= cfg_data[SIZE_W-1:0];
					REG_SUB_HEIGHT: sub_height_q <= cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
			end else if (acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// read-before-write: a read returns the entry from two rows back
	always_ff @(posedge clk) begin
		if (acc) begin
			rd0_c_s1 <= vbank0_q[addr_c];
			rd0_n_s1 <= vbank0_q[addr_n];
			if (!cur) begin
				vbank0_q[addr_c] <= item.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd1_c_s1 <= vbank1_q[addr_c];
			rd1_n_s1 <= vbank1_q[addr_n];
			if (cur) begin
				vbank1_q[addr_c] <= item.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			coef_s1        <= cmem_q[addr_c];
			cmem_q[addr_c] <= {item.coef_x, item.coef_y};
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			val_s1   <= item.value;
			ax_s1    <= item.coef_x;
			ay_s1    <= item.coef_y;
			col_s1   <= col_q;
			row_s1   <= row_q;
			cur_s1   <= cur;
			c_gt0_s1 <= col_q != '0;
			c_gt1_s1 <= col_q > COL_W'(1);
			r_gt0_s1 <= row_q != '0;
			r_gt1_s1 <= row_q > ROW_W'(1);
			right_s1 <= !last_col;
		end
	end

	assign pick      = pend_s1 & (~pend_s1 + 3'd1);
	assign job_valid = valid_s1 && (pend_s1 != '0);
	assign push      = job_valid && job_ready;
	assign s1_done   = valid_s1 && ((pend_s1 == '0) || (job_ready && (pend_s1 == pick)));
	assign item_ready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
			pend_s1  <= {last_row && last_col, last_row && (col_q != '0), row_q != '0};
		end else begin
			if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (push) begin
				pend_s1 <= pend_s1 & ~pick;
			end
		end
	end

	assign prev_c  = cur_s1 ? rd0_c_s1 : rd1_c_s1;
	assign prev_n  = cur_s1 ? rd0_n_s1 : rd1_n_s1;
	assign prev2_c = cur_s1 ? rd1_c_s1 : rd0_c_s1;

	always_ff @(posedge clk) begin
		if (s1_done) begin
			v2_q  <= v1_q;
			v1_q  <= val_s1;
			ax1_q <= ax_s1;
			ay1_q <= ay_s1;
			pl_q  <= prev_c;
		end
	end

	// operand selection for the job being issued
	always_comb begin
		logic signed [VAL_W-1:0]  center, nb_up, nb_down, nb_left, nb_right;
		logic signed [COEF_W-1:0] jax, jay;
		logic [COL_W-1:0]         jcol;
		logic [ROW_W-1:0]         jrow;
		logic [CSUM_W-1:0]        sx, sy;

		center   = '0;
		nb_up    = '0;
		nb_down  = '0;
		nb_left  = '0;
		nb_right = '0;
		jax      = '0;
		jay      = '0;
		jcol     = col_s1;
		jrow     = row_s1;
		case (pick)
			PEND_ABOVE: begin
				center   = prev_c;
				jax      = coef_s1[2*COEF_W-1:COEF_W];
				jay      = coef_s1[COEF_W-1:0];
				nb_up    = val_s1;
				nb_down  = r_gt1_s1 ? prev2_c : '0;
				nb_left  = c_gt0_s1 ? pl_q : '0;
				nb_right = right_s1 ? prev_n : '0;
				jrow     = row_s1 - ROW_W'(1);
			end
			PEND_LEFT: begin
				center   = v1_q;
				jax      = ax1_q;
				jay      = ay1_q;
				nb_down  = r_gt0_s1 ? pl_q : '0;
				nb_left  = c_gt1_s1 ? v2_q : '0;
				nb_right = val_s1;
				jcol     = col_s1 - COL_W'(1);
			end
			PEND_SELF: begin
				center   = val_s1;
				jax      = ax_s1;
				jay      = ay_s1;
				nb_down  = r_gt0_s1 ? prev_c : '0;
				nb_left  = c_gt0_s1 ? v1_q : '0;
			end
			default: ;
		endcase

		sx = CSUM_W'(start_x_q) + CSUM_W'(jcol);
		sy = CSUM_W'(start_y_q) + CSUM_W'(jrow);

		job.center          = center;
		job.coef_x          = jax;
		job.coef_y          = jay;
		job.sum_xy          = SUMXY_W'(jax) + SUMXY_W'(jay);
		job.sum_ud          = SUM_W'(nb_up) + SUM_W'(nb_down);
		job.sum_lr          = SUM_W'(nb_left) + SUM_W'(nb_right);
		job.tag.col         = POS_W'(sx % GRID_SIZE);
		job.tag.row         = POS_W'(sy % GRID_SIZE);
		job.tag.last_of_run = (pend_s1 & ~pick) == '0;
		job.tag.block_done  = pick == PEND_SELF;
	end

endmodule

// ===== rtl/core/psn_fifo.sv =====
// Short job queue between front and back; register array, one read port.
// Depends on psn_pkg.
module psn_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  psn_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output psn_pkg::job_t pop_data
);
	import psn_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push, pop;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/psn_back.sv =====
// Back end: multiply, sum, round and saturate, then the output register.
// Depends on psn_pkg; pulls jobs from psn_fifo.
module psn_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  psn_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_ready,
	output psn_pkg::res_t res
);
	import psn_pkg::*;

	logic                     en;
	logic                     valid_s2, valid_s3, res_valid_q;
	logic signed [PROD_W-1:0] p0_s2, p1_s2, p2_s2;
	logic signed [ACC_W-1:0]  acc_s3, rnd, shf, sat;
	tag_t                     tag_s2, tag_s3;
	res_t                     res_q;

	// whole pipe stalls together while the output waits
	assign en        = !res_valid_q || res_ready;
	assign job_ready = en;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			valid_s2    <= job_valid;
			valid_s3    <= valid_s2;
			res_valid_q <= valid_s3;
		end
	end

	// rounding: add half an LSB at 28 fraction bits, floor to 16
	always_comb begin
		rnd = acc_s3 + ROUND_HALF;
		shf = rnd >>> FRAC_SHIFT;
		if (shf > SAT_MAX) begin
			sat = SAT_MAX;
		end else if (shf < SAT_MIN) begin
			sat = SAT_MIN;
		end else begin
			sat = shf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2  <= PROD_W'(job.sum_xy) * PROD_W'(job.center);
			p1_s2  <= PROD_W'(job.coef_y) * PROD_W'(job.sum_ud);
			p2_s2  <= PROD_W'(job.coef_x) * PROD_W'(job.sum_lr);
			tag_s2 <= job.tag;

			acc_s3 <= (ACC_W'(p0_s2) <<< 1) - ACC_W'(p1_s2) - ACC_W'(p2_s2);
			tag_s3 <= tag_s2;

			res_q.result      <= sat[VAL_W-1:0];
			res_q.col         <= tag_s3.col;
			res_q.row         <= tag_s3.row;
			res_q.last_of_run <= tag_s3.last_of_run;
			res_q.block_done  <= tag_s3.block_done;
		end
	end

endmodule

// ===== rtl/core/poisson_five_point_stencil.sv =====
// A result passes stage 1, the job queue, the product and sum registers and the output
// register after the input transaction that completes it, behind earlier results of that input.
// Throughput: one input transaction per cycle while the single back-end pipeline drains one
// result per cycle; a last-row input yields up to two results (three at its final column).
// Reset (arst_n low, asynchronous) clears counters, queue and valids; config returns to
// start 0,0 and size 1x1. Row buffers are not cleared and need no clearing pass.
//
// Top level of the five-point Poisson stencil. Depends on psn_pkg, psn_front,
// psn_fifo and psn_back.
module poisson_five_point_stencil (
	input  logic                          clk,
	input  logic                          arst_n,

	// register writes; always ready, legal only while the block is idle
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psn_pkg::CFG_DATA_W-1:0] cfg_data,

	// grid samples in raster order, column fastest
	input  logic                          item_valid,
	output logic                          item_ready,
	input  psn_pkg::item_t                item,

	// finished points with full-grid coordinates
	output logic                          res_valid,
	input  logic                          res_ready,
	output psn_pkg::res_t                 res
);
	import psn_pkg::*;

	// front -> queue
	logic job_in_valid, job_in_ready;
	job_t job_in;
	// queue -> back
	logic job_out_valid, job_out_ready;
	job_t job_out;

	assign cfg_ready = 1'b1;

	// Front: one transaction per cycle into stage 1 while stage 1 is empty or releasing. The row
	// buffers are read at the accept edge (read-before-write), so stage 1 holds the row above,
	// the row two up and the coefficient row. Stage 1 then issues up to three jobs, one per cycle
	// while the queue has room, and only releases input when its last job is in the queue.
	psn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.job_valid  (job_in_valid),
		.job_ready  (job_in_ready),
		.job        (job_in)
	);

	// Queue decouples issue from the arithmetic so either side may stall.
	psn_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_in_valid),
		.push_ready (job_in_ready),
		.push_data  (job_in),
		.pop_valid  (job_out_valid),
		.pop_ready  (job_out_ready),
		.pop_data   (job_out)
	);

	// Back: products, sum, round/saturate into the output register; result transactions
	// complete in job order, so ordering matches issue order.
	psn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_out_valid),
		.job_ready  (job_out_ready),
		.job        (job_out),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

// ===== rtl/core/psn_checker.sv =====
// Port-level checks for the stencil top level, attached with bind.
// Depends on psn_pkg and poisson_five_point_stencil.
module psn_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          item_valid,
	input logic          item_ready,
	input logic          res_valid,
	input logic          res_ready,
	input psn_pkg::res_t res
);
	import psn_pkg::*;

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			seen_q <= 1'b1;
		end
	end

	// a stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// the block's final point always closes its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.block_done |-> res.last_of_run)
		else $error("block_done without last_of_run");

	// no result before any input transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> !res_valid)
		else $error("result before any input");

endmodule

bind poisson_five_point_stencil psn_checker u_psn_checker (.*);
